FILE: rtl/fbfla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfla_pkg
// Types, codes and defaults shared by the block free-list allocator.
// ----------------------------------------------------------------------------
package fbfla_pkg;

  localparam int POOL_DEPTH_DEF     = 256;
  localparam int OVERFLOW_WIDTH_DEF = 16;

  localparam int IDX_W       = 8;
  localparam int CAP_W       = 9;
  localparam int STATUS_W    = 3;
  localparam int OVF_OUT_W   = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 9;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_TAKEN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_POOL_CAPACITY   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FALLBACK_ENABLE = 1'b1;

  localparam logic [CAP_W-1:0] CAPACITY_RST = 9'd256;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] handle_index;
    logic             handle_overflow;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [IDX_W-1:0]     granted_index;
    logic                 granted_overflow;
    logic [CAP_W-1:0]     used_count;
    logic [OVF_OUT_W-1:0] overflow_count;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic commit;
  } ctl_cmd_t;

endpackage

FILE: rtl/fbfla_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfla_chan_if
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface fbfla_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/fixed_block_free_list_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_core
// Fixed-size block allocator: LIFO free list, then bump pointer, then
// counted overflow blocks.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake        | payload
//   in_ch    | in  | valid/ready      | cmd, handle_index, handle_overflow
//   out_ch   | out | valid/ready      | status, granted_index, granted_overflow,
//            |     |                  | used_count, overflow_count
//   cfg_*    | in  | write enable     | cfg_index, cfg_wdata
//
// Each item is accepted, which issues the link RAM read of the head's
// successor and the taken-flag RAM read, and is then committed in the exec
// state into the output register.
// A new item is taken while a result waits; commit stalls on a full output.
// Reset and a pool_capacity write clear all pool state; taken
// flags at or above the bump pointer count as free.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_core #(
  parameter int POOL_DEPTH     = fbfla_pkg::POOL_DEPTH_DEF,
  parameter int OVERFLOW_WIDTH = fbfla_pkg::OVERFLOW_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  fbfla_chan_if.sink                        in_ch,
  fbfla_chan_if.source                      out_ch,
  input  logic                              cfg_we,
  input  logic [fbfla_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fbfla_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  fbfla_pkg::ctl_cmd_t cmd;

  fbfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  fbfla_dp #(
    .POOL_DEPTH     (POOL_DEPTH),
    .OVERFLOW_WIDTH (OVERFLOW_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .req       (in_ch.data),
    .rsp       (out_ch.data)
  );

endmodule

FILE: rtl/fbfla_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfla_ram
// Generic RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/fbfla_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfla_ctrl
// Sequencer: accept, link read, commit into the output register.
// ----------------------------------------------------------------------------
module fbfla_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output fbfla_pkg::ctl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic commit;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign cmd.load   = accept;
  assign cmd.rd_en  = accept;
  assign cmd.commit = commit;

  a_commit_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (state_r == S_IDLE) && out_valid_r)
    else $error("commit did not present a result");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> !accept)
    else $error("accepted while busy");

  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accept did not start execution");

endmodule

FILE: rtl/fbfla_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfla_dp
// Allocator datapath: config, free-list head, bump pointer, counters,
// taken-flag RAM, link RAM and output register.
// ----------------------------------------------------------------------------
module fbfla_dp #(
  parameter int POOL_DEPTH     = fbfla_pkg::POOL_DEPTH_DEF,
  parameter int OVERFLOW_WIDTH = fbfla_pkg::OVERFLOW_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fbfla_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fbfla_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  fbfla_pkg::ctl_cmd_t                 cmd,
  input  fbfla_pkg::req_t                     req,
  output fbfla_pkg::rsp_t                     rsp
);

  localparam int DEPTH = (POOL_DEPTH < 256) ? POOL_DEPTH : 256;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [fbfla_pkg::CAP_W-1:0] DEPTH_C = fbfla_pkg::CAP_W'(DEPTH);

  logic [fbfla_pkg::CAP_W-1:0] cap_r;
  logic                        fb_r;
  logic [AW-1:0]               head_r, head_nxt;
  logic                        flv_r, flv_nxt;
  logic [fbfla_pkg::CAP_W-1:0] bump_r, bump_nxt;
  logic [fbfla_pkg::CAP_W-1:0] tt_r, tt_nxt;
  logic [OVERFLOW_WIDTH-1:0]   ovf_r, ovf_nxt;
  fbfla_pkg::req_t             req_r;
  fbfla_pkg::rsp_t             rsp_r, rsp_nxt;

  logic [fbfla_pkg::CAP_W-1:0] cap_eff;
  logic                        clear;
  logic                        tk_we;
  logic [AW-1:0]               tk_idx;
  logic                        tk_val;
  logic [AW-1:0]               tk_raddr;
  logic                        tk_rdata;
  logic                        req_taken;
  logic                        lk_we;
  logic [AW-1:0]               lk_wdata;
  logic [AW-1:0]               lk_rdata;
  logic [AW-1:0]               req_idx;

  assign clear    = cfg_we && (cfg_index == fbfla_pkg::CFG_POOL_CAPACITY);
  assign cap_eff  = (cap_r > DEPTH_C) ? DEPTH_C : cap_r;
  assign req_idx  = req_r.handle_index[AW-1:0];
  assign tk_raddr = req.handle_index[AW-1:0];
  // entries at or above the bump pointer have not been handed out since the last clear
  assign req_taken = tk_rdata && (fbfla_pkg::CAP_W'(req_idx) < bump_r);

  fbfla_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (req_idx),
    .wdata (lk_wdata),
    .re    (cmd.rd_en),
    .raddr (head_r),
    .rdata (lk_rdata)
  );

  fbfla_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_taken_ram (
    .clk   (clk),
    .we    (tk_we),
    .waddr (tk_idx),
    .wdata (tk_val),
    .re    (cmd.rd_en),
    .raddr (tk_raddr),
    .rdata (tk_rdata)
  );

  always_comb begin
    head_nxt = head_r;
    flv_nxt  = flv_r;
    bump_nxt = bump_r;
    tt_nxt   = tt_r;
    ovf_nxt  = ovf_r;
    tk_we    = 1'b0;
    tk_idx   = req_idx;
    tk_val   = 1'b0;
    lk_we    = 1'b0;
    lk_wdata = flv_r ? head_r : '0;
    rsp_nxt  = '0;
    rsp_nxt.status = fbfla_pkg::ST_OK;
    if (cmd.commit) begin
      if (req_r.cmd == fbfla_pkg::CMD_ALLOC) begin
        if (flv_r && (fbfla_pkg::CAP_W'(head_r) < cap_eff)) begin
          rsp_nxt.granted_index = fbfla_pkg::IDX_W'(head_r);
          tk_we    = 1'b1;
          tk_idx   = head_r;
          tk_val   = 1'b1;
          tt_nxt   = tt_r + 1'b1;
          head_nxt = lk_rdata;
          flv_nxt  = (bump_r > tt_nxt);
        end else if (bump_r < cap_eff) begin
          rsp_nxt.granted_index = bump_r[fbfla_pkg::IDX_W-1:0];
          tk_we    = 1'b1;
          tk_idx   = bump_r[AW-1:0];
          tk_val   = 1'b1;
          tt_nxt   = tt_r + 1'b1;
          bump_nxt = bump_r + 1'b1;
        end else if (fb_r && (ovf_r != '1)) begin
          ovf_nxt = ovf_r + 1'b1;
          rsp_nxt.granted_overflow = 1'b1;
        end else begin
          rsp_nxt.status = fbfla_pkg::ST_EMPTY;
        end
      end else if (req_r.handle_overflow) begin
        if (ovf_r == '0) begin
          rsp_nxt.status = fbfla_pkg::ST_UNDERFLOW;
        end else begin
          ovf_nxt = ovf_r - 1'b1;
        end
      end else if (fbfla_pkg::CAP_W'(req_r.handle_index) >= cap_eff) begin
        rsp_nxt.status = fbfla_pkg::ST_BAD_INDEX;
      end else if (!req_taken) begin
        rsp_nxt.status = fbfla_pkg::ST_NOT_TAKEN;
      end else begin
        tk_we    = 1'b1;
        lk_we    = 1'b1;
        head_nxt = req_idx;
        flv_nxt  = 1'b1;
        tt_nxt   = tt_r - 1'b1;
      end
    end
    rsp_nxt.used_count     = tt_nxt;
    rsp_nxt.overflow_count = fbfla_pkg::OVF_OUT_W'(ovf_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= fbfla_pkg::CAPACITY_RST;
      fb_r    <= 1'b0;
      head_r  <= '0;
      flv_r   <= 1'b0;
      bump_r  <= '0;
      tt_r    <= '0;
      ovf_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          fbfla_pkg::CFG_POOL_CAPACITY:   cap_r <= cfg_wdata;
          fbfla_pkg::CFG_FALLBACK_ENABLE: fb_r  <= cfg_wdata[0];
        endcase
      end
      if (clear) begin
        head_r  <= '0;
        flv_r   <= 1'b0;
        bump_r  <= '0;
        tt_r    <= '0;
        ovf_r   <= '0;
      end else begin
        head_r <= head_nxt;
        flv_r  <= flv_nxt;
        bump_r <= bump_nxt;
        tt_r   <= tt_nxt;
        ovf_r  <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req;
    end
    if (cmd.commit) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign rsp = rsp_r;

  // free list length is bump_r - tt_r
  a_list_valid: assert property (@(posedge clk) disable iff (!rst_n)
    flv_r == (bump_r != tt_r))
    else $error("free list valid flag out of step with counters");

  a_taken_le_bump: assert property (@(posedge clk) disable iff (!rst_n)
    tt_r <= bump_r)
    else $error("taken count above bump pointer");

  a_bump_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r <= cap_eff)
    else $error("bump pointer above capacity");

endmodule
